// ----- rtl/assert_macros.svh -----
// Assertion macros for the tour reverser RTL, used by ctsr_seq.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Antecedent holds in a cycle -> consequent holds in the same cycle.
`define CTSR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ctsr: assertion failed");

// Antecedent holds in a cycle -> consequent holds in the next cycle.
`define CTSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ctsr: assertion failed");

`else

`define CTSR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define CTSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/ctsr_pkg.sv -----
// Shared types and constants for the circular tour two-opt reverser.
// No dependencies; imported by every module of the block.
`default_nettype none

package ctsr_pkg;

  localparam int MAX_POINTS_DEF = 256;
  localparam int TOWN_CNT_W     = 9;
  localparam int IDX_W          = 8;
  localparam int TOWN_W         = 8;
  localparam int STATUS_W       = 3;
  localparam int MIN_POINTS     = 4;
  localparam logic [TOWN_CNT_W-1:0] TOWN_CNT_RST = 9'd256;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_TWO_OPT = 2'd2,
    OP_CHECK   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_BAD_A    = 3'd1,
    ST_BAD_B    = 3'd2,
    ST_ADJACENT = 3'd3,
    ST_EQUAL    = 3'd4
  } status_t;

  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  index_a;
    logic [IDX_W-1:0]  index_b;
    logic [TOWN_W-1:0] town_value;
  } req_t;

  typedef struct packed {
    logic [TOWN_W-1:0]   read_value;
    logic [STATUS_W-1:0] status;
    logic                tour_valid;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/ctsr_mem.sv -----
// Tour store: one write port and one registered read port.
// Uses widths from ctsr_pkg; instantiated by ctsr_seq.
`default_nettype none

module ctsr_mem
  import ctsr_pkg::*;
#(
  parameter int DEPTH = MAX_POINTS_DEF,
  parameter int AW    = $clog2(MAX_POINTS_DEF)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [TOWN_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output logic      [TOWN_W-1:0] rd_data
);

  logic [TOWN_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ctsr_seq.sv -----
// Operation sequencer: decodes a request, walks the tour store for
// two-opt swaps and checks, and holds the result. Uses ctsr_pkg, ctsr_mem.
`default_nettype none
`include "assert_macros.svh"

module ctsr_seq
  import ctsr_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic [((($clog2(MAX_POINTS+1)) > TOWN_CNT_W) ?
                     $clog2(MAX_POINTS+1) : TOWN_CNT_W)-1:0] n,
  input  wire logic req_valid,
  input  wire req_t req,
  output logic      req_ready,
  output logic      res_valid,
  output res_t      res,
  input  wire logic res_take
);

  localparam int CW = (($clog2(MAX_POINTS+1)) > TOWN_CNT_W) ?
                      $clog2(MAX_POINTS+1) : TOWN_CNT_W;
  localparam int AW = $clog2(MAX_POINTS);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RDV  = 8'b0000_0010,
    S_RD_P = 8'b0000_0100,
    S_RD_Q = 8'b0000_1000,
    S_WR_P = 8'b0001_0000,
    S_WR_Q = 8'b0010_0000,
    S_CHK  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [CW-1:0]     p_r, p_nxt;
  logic [CW-1:0]     q_r, q_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     k_r, k_nxt;
  logic              pend_r, pend_nxt;
  logic [TOWN_W-1:0] tmp_r, tmp_nxt;
  logic [TOWN_W-1:0] rv_r, rv_nxt;
  status_t           st_r, st_nxt;
  logic              tv_r, tv_nxt;

  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [TOWN_W-1:0] wr_data, rd_data;

  logic [CW-1:0]     a_ext, b_ext, rd_ext, len;
  logic              a_bad, b_bad, adj, same;

  function automatic logic [CW-1:0] inc_wrap(input logic [CW-1:0] v,
                                             input logic [CW-1:0] lim);
    logic [CW-1:0] s;
    s = v + CW'(1);
    return (s == lim) ? '0 : s;
  endfunction

  function automatic logic [CW-1:0] dec_wrap(input logic [CW-1:0] v,
                                             input logic [CW-1:0] lim);
    return (v == '0) ? (lim - CW'(1)) : (v - CW'(1));
  endfunction

  ctsr_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign a_ext  = {{(CW-IDX_W){1'b0}}, req.index_a};
  assign b_ext  = {{(CW-IDX_W){1'b0}}, req.index_b};
  assign rd_ext = {{(CW-TOWN_W){1'b0}}, rd_data};
  assign a_bad  = (a_ext >= n);
  assign b_bad  = (b_ext >= n);
  assign adj    = (inc_wrap(a_ext, n) == b_ext) || (inc_wrap(b_ext, n) == a_ext);
  assign same   = (a_ext == b_ext);
  // segment i+1..j, wrapping past the end of the tour when j < i
  assign len    = (b_ext > a_ext) ? (b_ext - a_ext) : (n - a_ext + b_ext);

  assign req_ready      = (state_r == S_IDLE);
  assign res_valid      = (state_r == S_DONE);
  assign res.read_value = rv_r;
  assign res.status     = st_r;
  assign res.tour_valid = tv_r;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    p_nxt     = p_r;
    q_nxt     = q_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    pend_nxt  = pend_r;
    tmp_nxt   = tmp_r;
    rv_nxt    = rv_r;
    st_nxt    = st_r;
    tv_nxt    = tv_r;
    wr_en     = 1'b0;
    wr_addr   = p_r[AW-1:0];
    wr_data   = rd_data;
    rd_en     = 1'b0;
    rd_addr   = p_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          op_nxt = req.op;
          rv_nxt = '0;
          st_nxt = ST_OK;
          tv_nxt = 1'b0;
          case (req.op)
            OP_WRITE: begin
              if (a_bad) begin
                st_nxt = ST_BAD_A;
              end else begin
                wr_en   = 1'b1;
                wr_addr = a_ext[AW-1:0];
                wr_data = req.town_value;
              end
              state_nxt = S_DONE;
            end
            OP_READ: begin
              if (a_bad) begin
                st_nxt    = ST_BAD_A;
                state_nxt = S_DONE;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = a_ext[AW-1:0];
                state_nxt = S_RDV;
              end
            end
            OP_TWO_OPT: begin
              state_nxt = S_DONE;
              if (a_bad) begin
                st_nxt = ST_BAD_A;
              end else if (b_bad) begin
                st_nxt = ST_BAD_B;
              end else if (adj) begin
                st_nxt = ST_ADJACENT;
              end else if (same) begin
                st_nxt = ST_EQUAL;
              end else begin
                p_nxt     = inc_wrap(a_ext, n);
                q_nxt     = b_ext;
                cnt_nxt   = len >> 1;
                state_nxt = S_RD_P;
              end
            end
            OP_CHECK: begin
              k_nxt     = '0;
              pend_nxt  = 1'b0;
              tv_nxt    = 1'b1;
              state_nxt = S_CHK;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_RDV: begin
        rv_nxt    = rd_data;
        state_nxt = S_DONE;
      end
      S_RD_P: begin
        rd_en     = 1'b1;
        rd_addr   = p_r[AW-1:0];
        state_nxt = S_RD_Q;
      end
      S_RD_Q: begin
        rd_en     = 1'b1;
        rd_addr   = q_r[AW-1:0];
        tmp_nxt   = rd_data;
        state_nxt = S_WR_P;
      end
      S_WR_P: begin
        wr_en     = 1'b1;
        wr_addr   = p_r[AW-1:0];
        wr_data   = rd_data;
        state_nxt = S_WR_Q;
      end
      S_WR_Q: begin
        wr_en   = 1'b1;
        wr_addr = q_r[AW-1:0];
        wr_data = tmp_r;
        p_nxt   = inc_wrap(p_r, n);
        q_nxt   = dec_wrap(q_r, n);
        cnt_nxt = cnt_r - CW'(1);
        state_nxt = (cnt_r == CW'(1)) ? S_DONE : S_RD_P;
      end
      S_CHK: begin
        // issue one read per cycle, compare each entry when it returns in the next cycle
        if (k_r != n) begin
          rd_en   = 1'b1;
          rd_addr = k_r[AW-1:0];
          k_nxt   = k_r + CW'(1);
        end
        pend_nxt = (k_r != n);
        if (pend_r && (rd_ext >= n)) begin
          tv_nxt = 1'b0;
        end
        if ((k_r == n) && !pend_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    p_r    <= p_nxt;
    q_r    <= q_nxt;
    cnt_r  <= cnt_nxt;
    k_r    <= k_nxt;
    pend_r <= pend_nxt;
    tmp_r  <= tmp_nxt;
    rv_r   <= rv_nxt;
    st_r   <= st_nxt;
    tv_r   <= tv_nxt;
  end

  logic swap_st;
  assign swap_st = (state_r == S_RD_P) || (state_r == S_RD_Q) ||
                   (state_r == S_WR_P) || (state_r == S_WR_Q);

  `CTSR_ASSERT_IMPL(a_swap_ends_differ, clk, rst_n, swap_st, p_r != q_r)
  `CTSR_ASSERT_IMPL(a_swap_count_live, clk, rst_n, swap_st, cnt_r != '0)
  `CTSR_ASSERT_IMPL(a_read_in_range, clk, rst_n, rd_en, {{(CW-AW){1'b0}}, rd_addr} < n)
  `CTSR_ASSERT_NEXT(a_result_holds, clk, rst_n, res_valid && !res_take, res_valid && $stable(res))
  `CTSR_ASSERT_IMPL(a_valid_only_check, clk, rst_n, res_valid && (op_r != OP_CHECK), !res.tour_valid)

endmodule

`default_nettype wire

// ----- rtl/circular_tour_two_opt_reverser_unit.sv -----
// Circular tour two-opt reverser: top level with configuration register
// and result register. Uses ctsr_pkg and ctsr_seq (which holds ctsr_mem).
//
// Usage:
//   Input requests (in_operation, in_index_a, in_index_b, in_town_value) are
//   taken when in_valid is high and in_stall is low. One request is worked
//   on at a time; in_stall stays high until its result is handed to the
//   result register.
//   Results (out_read_value, out_status, out_tour_valid) leave on out_valid;
//   the receiver holds them with out_stall. A new request may be accepted
//   while a result still waits on a stalled output.
//   cfg_wr_en/cfg_wr_data load the town count; write it only while idle.
// The tour store has one read and one write port, so a swap reads both
//   ends and then writes both back, and a check reads one entry per cycle.
// Reset: the town count returns to 256 and the control logic goes idle. Tour
//   contents are not cleared; every position in use must be written before
//   it is read, moved or checked.
`default_nettype none

module circular_tour_two_opt_reverser_unit
  import ctsr_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [TOWN_CNT_W-1:0] cfg_wr_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            in_operation,
  input  wire logic [IDX_W-1:0]      in_index_a,
  input  wire logic [IDX_W-1:0]      in_index_b,
  input  wire logic [TOWN_W-1:0]     in_town_value,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [TOWN_W-1:0]          out_read_value,
  output logic [STATUS_W-1:0]        out_status,
  output logic                       out_tour_valid
);

  localparam int CW = (($clog2(MAX_POINTS+1)) > TOWN_CNT_W) ?
                      $clog2(MAX_POINTS+1) : TOWN_CNT_W;
  localparam logic [CW-1:0] MAX_N = CW'(MAX_POINTS);
  localparam logic [CW-1:0] MIN_N = CW'(MIN_POINTS);

  logic [TOWN_CNT_W-1:0] town_cnt_r;
  logic [CW-1:0]         np_ext, n;
  logic                  out_valid_r;
  res_t                  out_res_r;
  req_t                  req;
  res_t                  res;
  logic                  req_ready, res_valid, res_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      town_cnt_r <= TOWN_CNT_RST;
    end else if (cfg_wr_en) begin
      town_cnt_r <= cfg_wr_data;
    end
  end

  // clamp the town count to the supported range
  assign np_ext = CW'(town_cnt_r);
  assign n      = (np_ext < MIN_N) ? MIN_N : ((np_ext > MAX_N) ? MAX_N : np_ext);

  assign req.op         = op_t'(in_operation);
  assign req.index_a    = in_index_a;
  assign req.index_b    = in_index_b;
  assign req.town_value = in_town_value;

  ctsr_seq #(
    .MAX_POINTS (MAX_POINTS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .n         (n),
    .req_valid (in_valid),
    .req       (req),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  assign in_stall = !req_ready;
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_res_r.read_value;
  assign out_status     = out_res_r.status;
  assign out_tour_valid = out_res_r.tour_valid;

endmodule

`default_nettype wire
